### sv/mmcc_pkg.sv
package mmcc_pkg;

  // fixed sizes of the player protocol
  localparam int REPLY_LENGTH = 10;
  localparam int MAX_FOLDERS  = 8;

  // command kinds on the input tuser
  localparam logic [3:0] K_PLAY       = 4'd0;
  localparam logic [3:0] K_PAUSE      = 4'd1;
  localparam logic [3:0] K_CONTINUE   = 4'd2;
  localparam logic [3:0] K_NEXT       = 4'd3;
  localparam logic [3:0] K_PREV       = 4'd4;
  localparam logic [3:0] K_STOP       = 4'd5;
  localparam logic [3:0] K_SETVOL     = 4'd6;
  localparam logic [3:0] K_CHANGEVOL  = 4'd7;
  localparam logic [3:0] K_RANDOM     = 4'd8;
  localparam logic [3:0] K_RANDFOLDER = 4'd9;
  localparam logic [3:0] K_SLEEP      = 4'd10;
  localparam logic [3:0] K_WAKE       = 4'd11;
  localparam logic [3:0] K_QUERY      = 4'd12;
  localparam logic [3:0] K_REPLYBYTE  = 4'd13;

  // result kinds on the output tuser
  localparam logic OK_FRAME  = 1'b0;
  localparam logic OK_REPORT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_VOLUME   = 2'd0;
  localparam logic [1:0] CFG_FOLDERS      = 2'd1;
  localparam logic [1:0] CFG_SONG_COUNTS  = 2'd2;

  // frame bytes
  localparam logic [7:0] FR_START   = 8'h7E;
  localparam logic [7:0] FR_VERSION = 8'hFF;
  localparam logic [7:0] FR_LENGTH  = 8'h06;
  localparam logic [7:0] FR_NOACK   = 8'h00;
  localparam logic [7:0] FR_END     = 8'hEF;

  // module command codes
  localparam logic [7:0] CMD_PLAY_FOLDER = 8'h0F;
  localparam logic [7:0] CMD_PAUSE       = 8'h0E;
  localparam logic [7:0] CMD_CONTINUE    = 8'h0D;
  localparam logic [7:0] CMD_NEXT        = 8'h01;
  localparam logic [7:0] CMD_PREV        = 8'h02;
  localparam logic [7:0] CMD_STOP        = 8'h16;
  localparam logic [7:0] CMD_VOLUME      = 8'h06;
  localparam logic [7:0] CMD_SLEEP       = 8'h0A;
  localparam logic [7:0] CMD_WAKE        = 8'h0B;
  localparam logic [7:0] CMD_QUERY       = 8'h42;

  // reply byte that holds the playing status
  localparam logic [3:0] REPLY_STATUS_POS = 4'd6;
  localparam logic [3:0] REPLY_LAST_POS   = 4'(REPLY_LENGTH - 1);
  localparam logic [3:0] USED_MAX         = 4'(MAX_FOLDERS);

  typedef logic [4:0] addr_t;

  typedef enum logic [3:0] {
    U_WAIT,
    U_DISPATCH,
    U_REPLY,
    U_REPORT,
    U_LOAD,
    U_SUM,
    U_DIV,
    U_WALK,
    U_FCHK,
    U_EMIT
  } uop_t;

  // where the two data bytes of a frame come from
  typedef enum logic [2:0] {
    DS_ZERO,
    DS_INPUT,
    DS_VOLSET,
    DS_VOLCHG,
    DS_PICK,
    DS_RANDF
  } dsel_t;

  // state update done when a frame is loaded
  typedef enum logic [2:0] {
    UP_NONE,
    UP_PLAY,
    UP_NEXT,
    UP_PREV,
    UP_VOL,
    UP_QUERY
  } upd_t;

  typedef struct packed {
    uop_t       op;
    logic [7:0] cmd;
    dsel_t      dsel;
    upd_t       upd;
    addr_t      nxt;
  } ctrl_t;

  // microprogram addresses
  localparam addr_t A_IDLE     = 5'd0;
  localparam addr_t A_DISP     = 5'd1;
  localparam addr_t A_REPLY    = 5'd2;
  localparam addr_t A_REPORT   = 5'd3;
  localparam addr_t A_PLAY     = 5'd4;
  localparam addr_t A_PAUSE    = 5'd5;
  localparam addr_t A_CONTINUE = 5'd6;
  localparam addr_t A_NEXT     = 5'd7;
  localparam addr_t A_PREV     = 5'd8;
  localparam addr_t A_STOP     = 5'd9;
  localparam addr_t A_SETVOL   = 5'd10;
  localparam addr_t A_CHGVOL   = 5'd11;
  localparam addr_t A_SLEEP    = 5'd12;
  localparam addr_t A_WAKE     = 5'd13;
  localparam addr_t A_QUERY    = 5'd14;
  localparam addr_t A_RND_SUM  = 5'd15;
  localparam addr_t A_RND_DIV  = 5'd16;
  localparam addr_t A_RND_WALK = 5'd17;
  localparam addr_t A_RND_LOAD = 5'd18;
  localparam addr_t A_RF_CHK   = 5'd19;
  localparam addr_t A_RF_DIV   = 5'd20;
  localparam addr_t A_RF_LOAD  = 5'd21;
  localparam addr_t A_EMIT     = 5'd22;

  function automatic ctrl_t cw(input uop_t op, input logic [7:0] cmd, input dsel_t ds,
                               input upd_t up, input addr_t nx);
    ctrl_t w;
    w.op   = op;
    w.cmd  = cmd;
    w.dsel = ds;
    w.upd  = up;
    w.nxt  = nx;
    return w;
  endfunction

  // control store
  function automatic ctrl_t rom_word(input addr_t a);
    ctrl_t w;
    unique case (a)
      A_IDLE:     w = cw(U_WAIT,     FR_NOACK, DS_ZERO, UP_NONE, A_DISP);
      A_DISP:     w = cw(U_DISPATCH, FR_NOACK, DS_ZERO, UP_NONE, A_IDLE);
      A_REPLY:    w = cw(U_REPLY,    FR_NOACK, DS_ZERO, UP_NONE, A_REPORT);
      A_REPORT:   w = cw(U_REPORT,   FR_NOACK, DS_ZERO, UP_NONE, A_IDLE);
      A_PLAY:     w = cw(U_LOAD, CMD_PLAY_FOLDER, DS_INPUT, UP_PLAY, A_EMIT);
      A_PAUSE:    w = cw(U_LOAD, CMD_PAUSE,    DS_ZERO, UP_NONE, A_EMIT);
      A_CONTINUE: w = cw(U_LOAD, CMD_CONTINUE, DS_ZERO, UP_NONE, A_EMIT);
      A_NEXT:     w = cw(U_LOAD, CMD_NEXT,     DS_ZERO, UP_NEXT, A_EMIT);
      A_PREV:     w = cw(U_LOAD, CMD_PREV,     DS_ZERO, UP_PREV, A_EMIT);
      A_STOP:     w = cw(U_LOAD, CMD_STOP,     DS_ZERO, UP_NONE, A_EMIT);
      A_SETVOL:   w = cw(U_LOAD, CMD_VOLUME,   DS_VOLSET, UP_VOL, A_EMIT);
      A_CHGVOL:   w = cw(U_LOAD, CMD_VOLUME,   DS_VOLCHG, UP_VOL, A_EMIT);
      A_SLEEP:    w = cw(U_LOAD, CMD_SLEEP,    DS_ZERO, UP_NONE, A_EMIT);
      A_WAKE:     w = cw(U_LOAD, CMD_WAKE,     DS_ZERO, UP_NONE, A_EMIT);
      A_QUERY:    w = cw(U_LOAD, CMD_QUERY,    DS_ZERO, UP_QUERY, A_EMIT);
      A_RND_SUM:  w = cw(U_SUM,  FR_NOACK, DS_ZERO, UP_NONE, A_RND_DIV);
      A_RND_DIV:  w = cw(U_DIV,  FR_NOACK, DS_ZERO, UP_NONE, A_RND_WALK);
      A_RND_WALK: w = cw(U_WALK, FR_NOACK, DS_ZERO, UP_NONE, A_RND_LOAD);
      A_RND_LOAD: w = cw(U_LOAD, CMD_PLAY_FOLDER, DS_PICK, UP_PLAY, A_EMIT);
      A_RF_CHK:   w = cw(U_FCHK, FR_NOACK, DS_ZERO, UP_NONE, A_RF_DIV);
      A_RF_DIV:   w = cw(U_DIV,  FR_NOACK, DS_ZERO, UP_NONE, A_RF_LOAD);
      A_RF_LOAD:  w = cw(U_LOAD, CMD_PLAY_FOLDER, DS_RANDF, UP_PLAY, A_EMIT);
      A_EMIT:     w = cw(U_EMIT, FR_NOACK, DS_ZERO, UP_NONE, A_IDLE);
      default:    w = cw(U_WAIT, FR_NOACK, DS_ZERO, UP_NONE, A_DISP);
    endcase
    return w;
  endfunction

  // entry point of the routine for a command
  function automatic addr_t entry_of(input logic [3:0] kind, input logic pending);
    addr_t a;
    a = A_IDLE;
    if (kind == K_REPLYBYTE) begin
      a = pending ? A_REPLY : A_IDLE;
    end else if (!pending) begin
      unique case (kind)
        K_PLAY:       a = A_PLAY;
        K_PAUSE:      a = A_PAUSE;
        K_CONTINUE:   a = A_CONTINUE;
        K_NEXT:       a = A_NEXT;
        K_PREV:       a = A_PREV;
        K_STOP:       a = A_STOP;
        K_SETVOL:     a = A_SETVOL;
        K_CHANGEVOL:  a = A_CHGVOL;
        K_RANDOM:     a = A_RND_SUM;
        K_RANDFOLDER: a = A_RF_CHK;
        K_SLEEP:      a = A_SLEEP;
        K_WAKE:       a = A_WAKE;
        K_QUERY:      a = A_QUERY;
        default:      a = A_IDLE;
      endcase
    end
    return a;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [7:0] cmd,
                                            input logic [7:0] d1, input logic [7:0] d2);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = FR_START;
      3'd1:    b = FR_VERSION;
      3'd2:    b = FR_LENGTH;
      3'd3:    b = cmd;
      3'd4:    b = FR_NOACK;
      3'd5:    b = d1;
      3'd6:    b = d2;
      default: b = FR_END;
    endcase
    return b;
  endfunction

endpackage

### sv/mp3_module_command_controller.sv
// Serial command controller for a small MP3 player module. Each accepted command
// transaction on in_* becomes one 8-byte frame 7E FF 06 cmd 00 d1 d2 EF on out_*, one
// byte per transaction, with out_tlast on the EF byte; a query (0x42) then collects
// REPLY_LENGTH reply-byte transactions and answers with one report transaction
// (out_tuser = 1) that carries the current folder and song, or zeros when reply byte 6
// was zero. Commands other than reply bytes are dropped while a query is pending, and
// random picks with no songs or a bad folder send nothing. Control is a small
// microprogram stepping one control word per cycle except while it waits for a
// command or for a free output register. A plain command is accepted, dispatched and
// loaded, then sent one byte per cycle while out_tready stays high; a reply byte is
// accepted, dispatched and counted, the last one then sending the report. A random pick
// sums the song total, runs the shared one-bit-per-cycle remainder unit and walks the
// folders; a pick inside a folder checks that folder and runs the remainder unit.
// in_tready is high only while the sequencer waits for a command; the output register
// keeps a byte on offer independently, so a command can be taken before the last
// byte of the previous frame has been read. Configuration on cfg_* is written
// whenever cfg_we is high, also during a command, which then uses the new value.
module mp3_module_command_controller
  import mmcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // folder_number, song_number, volume_value, volume_delta, random_value, reply_byte
  input  logic [55:0] in_tdata,
  // kind
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_byte, active_folder, active_song
  output logic [23:0] out_tdata,
  // out_kind
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // configuration
  logic [5:0]  max_vol_r, max_vol_nxt;
  logic [3:0]  folders_r, folders_nxt;
  logic [63:0] counts_r, counts_nxt;

  // player state
  logic [5:0]  vol_lvl_r, vol_lvl_nxt;
  logic [7:0]  cur_folder_r, cur_folder_nxt;
  logic [7:0]  cur_song_r, cur_song_nxt;
  logic        pending_r, pending_nxt;
  logic [3:0]  reply_pos_r, reply_pos_nxt;
  logic [7:0]  status_r, status_nxt;

  // sequencer
  addr_t       pc_r, pc_nxt;
  logic [2:0]  byte_cnt_r, byte_cnt_nxt;
  ctrl_t       word;

  // captured command
  logic [3:0]  kind_r, kind_nxt;
  logic [55:0] arg_r, arg_nxt;

  // datapath
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  d1_r, d1_nxt;
  logic [7:0]  d2_r, d2_nxt;
  logic [10:0] acc_r, acc_nxt;
  logic [10:0] base_r, base_nxt;
  logic [3:0]  fidx_r, fidx_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [10:0] dvs_r, dvs_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [3:0]  div_cnt_r, div_cnt_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;
  logic        out_user_r, out_user_nxt;
  logic        out_last_r, out_last_nxt;

  // command argument fields
  logic [7:0]  a_folder, a_song, a_vol, a_reply;
  logic [7:0]  a_delta;
  logic [15:0] a_rand;

  logic [3:0]  used;
  logic        out_free;
  logic [7:0]  cnt_f;
  logic [7:0]  rf_idx;
  logic [7:0]  cnt_rf;
  logic [11:0] trial;
  logic [5:0]  vol_set;
  logic [5:0]  vol_chg;
  logic signed [8:0] vol_sum;
  logic [10:0] pick_off;
  logic [7:0]  sel_d1, sel_d2;

  assign a_folder = arg_r[7:0];
  assign a_song   = arg_r[15:8];
  assign a_vol    = arg_r[23:16];
  assign a_delta  = arg_r[31:24];
  assign a_rand   = arg_r[47:32];
  assign a_reply  = arg_r[55:48];

  assign word      = rom_word(pc_r);
  assign in_tready = (word.op == U_WAIT);
  assign out_free  = !out_valid_r || out_tready;

  // folders in use, limited to the hardware maximum
  assign used = (folders_r > USED_MAX) ? USED_MAX : folders_r;

  // song count of the folder under the walk index and of the requested folder
  assign cnt_f  = counts_r[{fidx_r[2:0], 3'b000} +: 8];
  assign rf_idx = a_folder - 8'd1;
  assign cnt_rf = counts_r[{rf_idx[2:0], 3'b000} +: 8];

  // one restoring step of the remainder unit
  assign trial = {rem_r, dvd_r[15]};

  // volume clamps
  assign vol_set = (a_vol > {2'b00, max_vol_r}) ? max_vol_r : a_vol[5:0];
  assign vol_sum = $signed({3'b000, vol_lvl_r}) + $signed({a_delta[7], a_delta});
  always_comb begin
    if (vol_sum < 0) begin
      vol_chg = 6'd0;
    end else if (vol_sum > $signed({3'b000, max_vol_r})) begin
      vol_chg = max_vol_r;
    end else begin
      vol_chg = vol_sum[5:0];
    end
  end

  // song within the picked folder, counted from zero
  assign pick_off = rem_r - base_r;

  // data bytes of the frame being loaded
  always_comb begin
    sel_d1 = 8'd0;
    sel_d2 = 8'd0;
    unique case (word.dsel)
      DS_ZERO: begin
        sel_d1 = 8'd0;
        sel_d2 = 8'd0;
      end
      DS_INPUT: begin
        sel_d1 = a_folder;
        sel_d2 = a_song;
      end
      DS_VOLSET: begin
        sel_d2 = {2'b00, vol_set};
      end
      DS_VOLCHG: begin
        sel_d2 = {2'b00, vol_chg};
      end
      DS_PICK: begin
        sel_d1 = {4'b0000, fidx_r};
        sel_d2 = pick_off[7:0] + 8'd1;
      end
      DS_RANDF: begin
        sel_d1 = a_folder;
        sel_d2 = rem_r[7:0] + 8'd1;
      end
      default: begin
        sel_d1 = 8'd0;
        sel_d2 = 8'd0;
      end
    endcase
  end

  // sequencer and datapath next state
  always_comb begin
    max_vol_nxt    = max_vol_r;
    folders_nxt    = folders_r;
    counts_nxt     = counts_r;
    vol_lvl_nxt    = vol_lvl_r;
    cur_folder_nxt = cur_folder_r;
    cur_song_nxt   = cur_song_r;
    pending_nxt    = pending_r;
    reply_pos_nxt  = reply_pos_r;
    status_nxt     = status_r;
    pc_nxt         = pc_r;
    byte_cnt_nxt   = byte_cnt_r;
    kind_nxt       = kind_r;
    arg_nxt        = arg_r;
    cmd_nxt        = cmd_r;
    d1_nxt         = d1_r;
    d2_nxt         = d2_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    fidx_nxt       = fidx_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    dvd_nxt        = dvd_r;
    div_cnt_nxt    = div_cnt_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_VOLUME:  max_vol_nxt = cfg_wdata[5:0];
        CFG_FOLDERS:     folders_nxt = cfg_wdata[3:0];
        CFG_SONG_COUNTS: counts_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    unique case (word.op)
      U_WAIT: begin
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          arg_nxt  = in_tdata;
          pc_nxt   = word.nxt;
        end
      end
      U_DISPATCH: begin
        acc_nxt  = 11'd0;
        fidx_nxt = 4'd0;
        pc_nxt   = entry_of(kind_r, pending_r);
      end
      U_REPLY: begin
        if (reply_pos_r == REPLY_STATUS_POS) begin
          status_nxt = a_reply;
        end
        if (reply_pos_r == REPLY_LAST_POS) begin
          reply_pos_nxt = 4'd0;
          pending_nxt   = 1'b0;
          pc_nxt        = word.nxt;
        end else begin
          reply_pos_nxt = reply_pos_r + 4'd1;
          pc_nxt        = A_IDLE;
        end
      end
      U_REPORT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = OK_REPORT;
          out_last_nxt  = 1'b1;
          out_data_nxt  = (status_r != 8'd0) ? {cur_song_r, cur_folder_r, 8'd0} : 24'd0;
          pc_nxt        = word.nxt;
        end
      end
      U_LOAD: begin
        cmd_nxt      = word.cmd;
        d1_nxt       = sel_d1;
        d2_nxt       = sel_d2;
        byte_cnt_nxt = 3'd0;
        unique case (word.upd)
          UP_NONE: ;
          UP_PLAY: begin
            cur_folder_nxt = sel_d1;
            cur_song_nxt   = sel_d2;
          end
          UP_NEXT: cur_song_nxt = cur_song_r + 8'd1;
          UP_PREV: cur_song_nxt = cur_song_r - 8'd1;
          UP_VOL:  vol_lvl_nxt  = sel_d2[5:0];
          UP_QUERY: begin
            pending_nxt   = 1'b1;
            reply_pos_nxt = 4'd0;
          end
          default: ;
        endcase
        pc_nxt = word.nxt;
      end
      U_SUM: begin
        // total over the used folders, one folder a cycle
        if (fidx_r < used) begin
          acc_nxt  = acc_r + {3'b000, cnt_f};
          fidx_nxt = fidx_r + 4'd1;
        end else if (acc_r == 11'd0) begin
          pc_nxt = A_IDLE;
        end else begin
          dvs_nxt     = acc_r;
          rem_nxt     = 11'd0;
          dvd_nxt     = a_rand;
          div_cnt_nxt = 4'd0;
          pc_nxt      = word.nxt;
        end
      end
      U_FCHK: begin
        if ((rf_idx >= {4'b0000, used}) || (cnt_rf == 8'd0)) begin
          pc_nxt = A_IDLE;
        end else begin
          dvs_nxt     = {3'b000, cnt_rf};
          rem_nxt     = 11'd0;
          dvd_nxt     = a_rand;
          div_cnt_nxt = 4'd0;
          pc_nxt      = word.nxt;
        end
      end
      U_DIV: begin
        // remainder of the random value, one dividend bit a cycle
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = 11'(trial - {1'b0, dvs_r});
        end else begin
          rem_nxt = trial[10:0];
        end
        dvd_nxt     = {dvd_r[14:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'd15) begin
          acc_nxt  = 11'd0;
          base_nxt = 11'd0;
          fidx_nxt = 4'd0;
          pc_nxt   = word.nxt;
        end
      end
      U_WALK: begin
        // find the folder that holds the picked index
        if ((acc_r <= rem_r) && (fidx_r < used)) begin
          base_nxt = acc_r;
          acc_nxt  = acc_r + {3'b000, cnt_f};
          fidx_nxt = fidx_r + 4'd1;
        end else begin
          pc_nxt = word.nxt;
        end
      end
      U_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = OK_FRAME;
          out_last_nxt  = (byte_cnt_r == 3'd7);
          out_data_nxt  = {16'd0, frame_byte(byte_cnt_r, cmd_r, d1_r, d2_r)};
          byte_cnt_nxt  = byte_cnt_r + 3'd1;
          if (byte_cnt_r == 3'd7) begin
            pc_nxt = word.nxt;
          end
        end
      end
      default: pc_nxt = A_IDLE;
    endcase
  end

  // control and player state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vol_r    <= 6'd30;
      folders_r    <= 4'd8;
      counts_r     <= 64'd0;
      vol_lvl_r    <= 6'd0;
      cur_folder_r <= 8'd0;
      cur_song_r   <= 8'd0;
      pending_r    <= 1'b0;
      reply_pos_r  <= 4'd0;
      status_r     <= 8'd0;
      pc_r         <= A_IDLE;
      byte_cnt_r   <= 3'd0;
      div_cnt_r    <= 4'd0;
      out_valid_r  <= 1'b0;
    end else begin
      max_vol_r    <= max_vol_nxt;
      folders_r    <= folders_nxt;
      counts_r     <= counts_nxt;
      vol_lvl_r    <= vol_lvl_nxt;
      cur_folder_r <= cur_folder_nxt;
      cur_song_r   <= cur_song_nxt;
      pending_r    <= pending_nxt;
      reply_pos_r  <= reply_pos_nxt;
      status_r     <= status_nxt;
      pc_r         <= pc_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      div_cnt_r    <= div_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    arg_r      <= arg_nxt;
    cmd_r      <= cmd_nxt;
    d1_r       <= d1_nxt;
    d2_r       <= d2_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    fidx_r     <= fidx_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    dvd_r      <= dvd_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // a query only ends through the reply routine
  a_query_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(pending_r) |-> $past(pc_r) == A_REPLY)
    else $error("query ended outside the reply routine");

  // reply position stays in range and rests at zero without a query
  a_reply_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (reply_pos_r <= REPLY_LAST_POS) && (pending_r || reply_pos_r == 4'd0))
    else $error("reply position out of range");

  // a frame is never cut short: the byte counter is back at zero when idle
  a_frame_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == A_IDLE) |-> (byte_cnt_r == 3'd0))
    else $error("frame byte counter not at zero while waiting");

endmodule
